[hdl/urde_pkg.sv]
// ----------------------------------------------------------------------------
// urde_pkg
// Shared types, codes and the byte-wide crc-8 step for the uart register
// datagram engine.
// ----------------------------------------------------------------------------
package urde_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ECHO_BAD    = 3'd1;
  localparam logic [2:0] ST_ECHO_MISS   = 3'd2;
  localparam logic [2:0] ST_NO_REPLY    = 3'd3;
  localparam logic [2:0] ST_BAD_CRC     = 3'd4;
  localparam logic [2:0] ST_BAD_SYNC    = 3'd5;
  localparam logic [2:0] ST_BAD_ADDRESS = 3'd6;

  localparam logic       KIND_TX   = 1'b0;
  localparam logic       KIND_DONE = 1'b1;

  localparam logic [7:0] SYNC_BYTE    = 8'h05;
  localparam logic [3:0] SYNC_NIBBLE  = 4'h5;
  localparam logic [7:0] REPLY_ADDR   = 8'hFF;
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  node_address;
    logic [6:0]  register_address;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [31:0] read_data;
    logic        last;
  } out_item_t;

  // group of results made by one input item, handed from core to emitter
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [3:0]  cnt;
    logic [63:0] bytes;
    logic [2:0]  status;
    logic [31:0] data;
  } grp_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[7] ^ b[k];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

[hdl/urde_core.sv]
// ----------------------------------------------------------------------------
// urde_core
// Link state machine: frames requests, checks echo and reply bytes, runs the
// tick timeout and hands result groups to the emitter.
// ----------------------------------------------------------------------------
module urde_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_v,
  input  urde_pkg::in_item_t item,
  input  logic [15:0]        timeout_ticks,
  input  logic               grp_free,
  output logic               advance,
  output urde_pkg::grp_t     grp
);

  typedef enum logic [1:0] {PH_IDLE, PH_ECHO, PH_REPLY} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sent_r [8];
  logic [7:0]  sent_nxt [8];
  logic        sent_we;
  logic [3:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  reply_crc_r, reply_crc_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [31:0] reply_data_r, reply_data_nxt;
  logic [1:0]  hdr_r, hdr_nxt;
  logic        is_read_r, is_read_nxt;

  logic [7:0]  b [8];
  logic [7:0]  crc_rd, crc_wr;
  logic [3:0]  cnt_inc, frame_len;
  logic [15:0] wait_inc;
  logic        rd_req;

  always_comb begin
    rd_req = (item.action == urde_pkg::ACT_READ);
    b[0] = urde_pkg::SYNC_BYTE;
    b[1] = {6'd0, item.node_address};
    b[2] = {~rd_req, item.register_address};
    b[3] = item.write_value[31:24];
    b[4] = item.write_value[23:16];
    b[5] = item.write_value[15:8];
    b[6] = item.write_value[7:0];
    crc_rd = urde_pkg::crc8_byte(urde_pkg::crc8_byte(urde_pkg::crc8_byte(8'h00, b[0]), b[1]),
                                 b[2]);
    crc_wr = urde_pkg::crc8_byte(urde_pkg::crc8_byte(urde_pkg::crc8_byte(
             urde_pkg::crc8_byte(crc_rd, b[3]), b[4]), b[5]), b[6]);
    b[7] = crc_wr;
    cnt_inc   = byte_cnt_r + 4'd1;
    frame_len = is_read_r ? 4'd4 : 4'd8;
    wait_inc  = (wait_r == 16'hFFFF) ? wait_r : wait_r + 16'd1;
  end

  always_comb begin
    phase_nxt      = phase_r;
    sent_nxt       = b;
    sent_we        = 1'b0;
    byte_cnt_nxt   = byte_cnt_r;
    reply_crc_nxt  = reply_crc_r;
    wait_nxt       = wait_r;
    reply_data_nxt = reply_data_r;
    hdr_nxt        = hdr_r;
    is_read_nxt    = is_read_r;
    grp            = '0;
    if (rd_req) begin
      sent_nxt[3] = crc_rd;
    end
    case (item.action)
      urde_pkg::ACT_WRITE, urde_pkg::ACT_READ: begin
        if (phase_r == PH_IDLE) begin
          is_read_nxt  = rd_req;
          sent_we      = 1'b1;
          phase_nxt    = PH_ECHO;
          byte_cnt_nxt = 4'd0;
          wait_nxt     = 16'd0;
          grp.valid    = 1'b1;
          grp.kind     = urde_pkg::KIND_TX;
          grp.cnt      = rd_req ? 4'd4 : 4'd8;
          grp.bytes    = {sent_nxt[0], sent_nxt[1], sent_nxt[2], sent_nxt[3],
                          sent_nxt[4], sent_nxt[5], sent_nxt[6], sent_nxt[7]};
        end
      end
      urde_pkg::ACT_RX: begin
        if (phase_r == PH_ECHO) begin
          if (item.rx_byte != sent_r[byte_cnt_r[2:0]]) begin
            grp.valid  = 1'b1;
            grp.status = urde_pkg::ST_ECHO_BAD;
          end else begin
            byte_cnt_nxt = cnt_inc;
            wait_nxt     = 16'd0;
            if (cnt_inc >= frame_len) begin
              if (!is_read_r) begin
                grp.valid  = 1'b1;
                grp.status = urde_pkg::ST_OK;
              end else begin
                phase_nxt      = PH_REPLY;
                byte_cnt_nxt   = 4'd0;
                reply_crc_nxt  = 8'h00;
                reply_data_nxt = 32'd0;
                hdr_nxt        = 2'b00;
              end
            end
          end
        end else if (phase_r == PH_REPLY) begin
          if (byte_cnt_r == 4'd7) begin
            grp.valid = 1'b1;
            if (item.rx_byte != reply_crc_r) begin
              grp.status = urde_pkg::ST_BAD_CRC;
            end else if (hdr_r[0]) begin
              grp.status = urde_pkg::ST_BAD_SYNC;
            end else if (hdr_r[1]) begin
              grp.status = urde_pkg::ST_BAD_ADDRESS;
            end else begin
              grp.status = urde_pkg::ST_OK;
              grp.data   = reply_data_r;
            end
          end else begin
            reply_crc_nxt = urde_pkg::crc8_byte(reply_crc_r, item.rx_byte);
            if (byte_cnt_r == 4'd0 && item.rx_byte[3:0] != urde_pkg::SYNC_NIBBLE) begin
              hdr_nxt[0] = 1'b1;
            end
            if (byte_cnt_r == 4'd1 && item.rx_byte != urde_pkg::REPLY_ADDR) begin
              hdr_nxt[1] = 1'b1;
            end
            if (byte_cnt_r >= 4'd3) begin
              reply_data_nxt = {reply_data_r[23:0], item.rx_byte};
            end
            byte_cnt_nxt = cnt_inc;
          end
        end
      end
      urde_pkg::ACT_TICK: begin
        if (phase_r == PH_ECHO || (phase_r == PH_REPLY && byte_cnt_r == 4'd0)) begin
          wait_nxt = wait_inc;
          if (wait_inc >= timeout_ticks) begin
            grp.valid  = 1'b1;
            grp.status = (phase_r == PH_ECHO) ? urde_pkg::ST_ECHO_MISS
                                              : urde_pkg::ST_NO_REPLY;
          end
        end
      end
      default: begin
      end
    endcase
    // completion closes the transaction
    if (grp.valid && grp.kind == urde_pkg::KIND_DONE || grp.valid && !sent_we) begin
      grp.kind     = urde_pkg::KIND_DONE;
      grp.cnt      = 4'd1;
      phase_nxt    = PH_IDLE;
      byte_cnt_nxt = 4'd0;
      wait_nxt     = 16'd0;
    end
    advance   = item_v && (!grp.valid || grp_free);
    grp.valid = grp.valid && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_cnt_r   <= 4'd0;
      reply_crc_r  <= 8'h00;
      wait_r       <= 16'd0;
      reply_data_r <= 32'd0;
      hdr_r        <= 2'b00;
      is_read_r    <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      reply_crc_r  <= reply_crc_nxt;
      wait_r       <= wait_nxt;
      reply_data_r <= reply_data_nxt;
      hdr_r        <= hdr_nxt;
      is_read_r    <= is_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sent_we) begin
      sent_r <= sent_nxt;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> byte_cnt_r == 4'd0 && wait_r == 16'd0)
    else $error("idle with live counters");

  a_reply_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_REPLY |-> byte_cnt_r <= 4'd7)
    else $error("reply byte count overrun");

  a_grp_closes: assert property (@(posedge clk) disable iff (!rst_n)
    grp.valid && grp.kind == urde_pkg::KIND_DONE |=> phase_r == PH_IDLE)
    else $error("completion left link busy");

endmodule

[hdl/urde_emit.sv]
// ----------------------------------------------------------------------------
// urde_emit
// Holds one result group and sends its items one per cycle through the
// output register, unless out_stall holds it.
// ----------------------------------------------------------------------------
module urde_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  urde_pkg::grp_t      grp,
  output logic                grp_free,
  output logic                out_valid,
  input  logic                out_stall,
  output urde_pkg::out_item_t out_data
);

  logic [3:0]          g_cnt_r;
  logic                g_kind_r;
  logic [63:0]         g_bytes_r;
  logic [2:0]          g_status_r;
  logic [31:0]         g_data_r;
  logic                out_v_r;
  urde_pkg::out_item_t out_r, item_nxt;
  logic                load_out;

  always_comb begin
    load_out           = (g_cnt_r != 4'd0) && (!out_v_r || !out_stall);
    grp_free           = (g_cnt_r == 4'd0) || (g_cnt_r == 4'd1 && load_out);
    item_nxt.kind      = g_kind_r;
    item_nxt.tx_byte   = g_bytes_r[63:56];
    item_nxt.status    = g_status_r;
    item_nxt.read_data = g_data_r;
    item_nxt.last      = (g_cnt_r == 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_cnt_r <= 4'd0;
      out_v_r <= 1'b0;
    end else begin
      if (grp.valid) begin
        g_cnt_r <= grp.cnt;
      end else if (load_out) begin
        g_cnt_r <= g_cnt_r - 4'd1;
      end
      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp.valid) begin
      g_kind_r   <= grp.kind;
      g_bytes_r  <= grp.bytes;
      g_status_r <= grp.status;
      g_data_r   <= grp.data;
    end else if (load_out) begin
      g_bytes_r <= {g_bytes_r[55:0], 8'h00};
    end
    if (load_out) begin
      out_r <= item_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    grp.valid |-> grp_free)
    else $error("group written over pending items");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    grp.valid && grp.kind == urde_pkg::KIND_DONE |-> grp.cnt == 4'd1)
    else $error("completion group longer than one item");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    g_cnt_r <= 4'd8)
    else $error("group count overrun");

endmodule

[hdl/uart_register_datagram_engine_unit.sv]
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_unit
// Master side of a single-wire uart register link with crc-8 datagrams.
//
//   channel  direction  handshake          payload
//   in_      in         valid / stall      urde_pkg::in_item_t
//   out_     out        valid / stall      urde_pkg::out_item_t
//   cfg_     in         valid / ready      tick timeout, 16 bit
//
// items without results are taken every cycle; out is registered
// a request fills the result group (4 or 8), which drains one item per cycle
// if not stalled; the input register holds an item while the group is full
// synchronous active-low reset; timeout returns to 10000 ticks
// out_stall holds the output register and the group; in_stall follows it back
// ----------------------------------------------------------------------------
module uart_register_datagram_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  urde_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output urde_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic               in_v_r;
  urde_pkg::in_item_t in_r;
  logic [15:0]        timeout_r;
  logic               advance;
  logic               grp_free;
  urde_pkg::grp_t     grp;

  assign in_stall  = in_v_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      timeout_r <= urde_pkg::TIMEOUT_RST;
    end else begin
      if (in_valid && !in_stall) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  urde_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_v        (in_v_r),
    .item          (in_r),
    .timeout_ticks (timeout_r),
    .grp_free      (grp_free),
    .advance       (advance),
    .grp           (grp)
  );

  urde_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .grp_free  (grp_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
